### sv/bxm_pkg.sv
`default_nettype none
package bxm_pkg;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [1:0] FUNC_ERASE  = 2'd2;
	localparam logic [1:0] FUNC_QUERY  = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOTFOUND = 3'd1;
	localparam logic [2:0] ST_DUP      = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	localparam logic REG_ALLOW_DUP = 1'b0;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_WRD,
		S_WCHK,
		S_IRD,
		S_ICHK,
		S_ICLR,
		S_LRD,
		S_LINC,
		S_ERD,
		S_EUPD,
		S_QRD,
		S_QCHK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic link_we0;
		logic link_we1;
		logic cnt_we;
		logic stk_we;
	} mem_ctl_t;

endpackage
`default_nettype wire

### sv/binary_trie_xor_min_set.sv
// channel   | signals                               | dir
// ----------+---------------------------------------+-----
// request   | in_valid, in_ready, func, key         | in
// result    | out_valid, out_ready, status,         | out
//           | match_key                             |
// config    | psel, penable, pwrite, paddr, pwdata, | in
//           | prdata, pready                        |
// Lookup walks down with a read and a check per level, query the same; insert does a
// duplicate walk (set mode only) down to the first missing node, then a read/update per
// level plus a clear on each new node; erase walks down, then does a count read/update
// per level going up.
// The single read port of each node memory sets the per-level cost. No clearing pass:
// reset is ready at once. in_ready is low while a request is in flight; one finished
// result is held in the output register while the next request is taken.
`default_nettype none
module binary_trie_xor_min_set import bxm_pkg::*; #(
	parameter int KEY_BITS   = 32,
	parameter int NODE_POOL  = 4096,
	parameter int COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [31:0] key,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [31:0]      match_key,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int NW = $clog2(NODE_POOL);

	logic                  allow_dup_q;
	logic                  out_valid_q;
	logic [2:0]            status_q;
	logic [31:0]           match_q;
	logic                  res_done;
	logic                  res_take;
	logic [2:0]            res_status;
	logic [31:0]           res_match;
	mem_ctl_t              ctl;
	logic [NW-1:0]         rd_addr;
	logic [NW-1:0]         link_waddr;
	logic [NW-1:0]         link_wdata;
	logic [NW-1:0]         cnt_waddr;
	logic [COUNT_BITS-1:0] cnt_wdata;
	logic [NW-1:0]         stk_raddr;
	logic [NW-1:0]         stk_waddr;
	logic [NW-1:0]         stk_wdata;
	logic [NW-1:0]         low_mark;
	logic [NW-1:0]         link0_rd;
	logic [NW-1:0]         link1_rd;
	logic [COUNT_BITS-1:0] cnt_rd;
	logic [NW-1:0]         stk_rd;
	logic                  reg_sel;

	assign pready   = 1'b1;
	assign reg_sel  = paddr[2] == REG_ALLOW_DUP && paddr[1:0] == 2'd0;
	assign prdata   = reg_sel ? {31'd0, allow_dup_q} : 32'd0;
	assign res_take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_dup_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && reg_sel) allow_dup_q <= pwdata[0];
			if (res_done && res_take) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_done && res_take) begin
			status_q <= res_status;
			match_q  <= (res_status == ST_OK) ? res_match : 32'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign match_key = match_q;

	bxm_ctrl #(
		.KEY_BITS   (KEY_BITS),
		.NODE_POOL  (NODE_POOL),
		.COUNT_BITS (COUNT_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (in_valid),
		.req_ready  (in_ready),
		.req_func   (func),
		.req_key    (key),
		.allow_dup  (allow_dup_q),
		.res_done   (res_done),
		.res_take   (res_take),
		.res_status (res_status),
		.res_match  (res_match),
		.ctl        (ctl),
		.rd_addr    (rd_addr),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.cnt_waddr  (cnt_waddr),
		.cnt_wdata  (cnt_wdata),
		.stk_raddr  (stk_raddr),
		.stk_waddr  (stk_waddr),
		.stk_wdata  (stk_wdata),
		.low_mark   (low_mark),
		.link0_rd   (link0_rd),
		.link1_rd   (link1_rd),
		.cnt_rd     (cnt_rd),
		.stk_rd     (stk_rd)
	);

	bxm_store #(
		.NODE_POOL  (NODE_POOL),
		.COUNT_BITS (COUNT_BITS)
	) u_store (
		.clk        (clk),
		.ctl        (ctl),
		.rd_addr    (rd_addr),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.cnt_waddr  (cnt_waddr),
		.cnt_wdata  (cnt_wdata),
		.stk_raddr  (stk_raddr),
		.stk_waddr  (stk_waddr),
		.stk_wdata  (stk_wdata),
		.low_mark   (low_mark),
		.link0_rd   (link0_rd),
		.link1_rd   (link1_rd),
		.cnt_rd     (cnt_rd),
		.stk_rd     (stk_rd)
	);

endmodule
`default_nettype wire

### sv/bxm_store.sv
`default_nettype none
module bxm_store import bxm_pkg::*; #(
	parameter int NODE_POOL  = 4096,
	parameter int COUNT_BITS = 16,
	localparam int NW = $clog2(NODE_POOL)
) (
	input  wire logic                  clk,
	input  wire mem_ctl_t              ctl,
	input  wire logic [NW-1:0]         rd_addr,
	input  wire logic [NW-1:0]         link_waddr,
	input  wire logic [NW-1:0]         link_wdata,
	input  wire logic [NW-1:0]         cnt_waddr,
	input  wire logic [COUNT_BITS-1:0] cnt_wdata,
	input  wire logic [NW-1:0]         stk_raddr,
	input  wire logic [NW-1:0]         stk_waddr,
	input  wire logic [NW-1:0]         stk_wdata,
	input  wire logic [NW-1:0]         low_mark,
	output logic [NW-1:0]              link0_rd,
	output logic [NW-1:0]              link1_rd,
	output logic [COUNT_BITS-1:0]      cnt_rd,
	output logic [NW-1:0]              stk_rd
);

	logic [NW-1:0]         link0_mem [NODE_POOL];
	logic [NW-1:0]         link1_mem [NODE_POOL];
	logic [COUNT_BITS-1:0] cnt_mem   [NODE_POOL];
	logic [NW-1:0]         stk_mem   [NODE_POOL];

	logic [NW-1:0] stk_rd_q;
	logic [NW-1:0] stk_base_q;
	logic          stk_fresh_q;

	always_ff @(posedge clk) begin
		if (ctl.link_we0) begin
			link0_mem[link_waddr] <= link_wdata;
		end
		if (ctl.link_we1) begin
			link1_mem[link_waddr] <= link_wdata;
		end
		if (ctl.cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (ctl.stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		link0_rd    <= link0_mem[rd_addr];
		link1_rd    <= link1_mem[rd_addr];
		cnt_rd      <= cnt_mem[rd_addr];
		stk_rd_q    <= stk_mem[stk_raddr];
		stk_fresh_q <= stk_raddr < low_mark;
		stk_base_q  <= stk_raddr + NW'(1);
	end

	// entries below the low mark were never pushed: they read as index + 1
	assign stk_rd = stk_fresh_q ? stk_base_q : stk_rd_q;

endmodule
`default_nettype wire

### sv/bxm_ctrl.sv
`default_nettype none
module bxm_ctrl import bxm_pkg::*; #(
	parameter int KEY_BITS   = 32,
	parameter int NODE_POOL  = 4096,
	parameter int COUNT_BITS = 16,
	localparam int NW = $clog2(NODE_POOL),
	localparam int LW = $clog2(KEY_BITS + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire logic [1:0]            req_func,
	input  wire logic [31:0]           req_key,
	input  wire logic                  allow_dup,
	output logic                       res_done,
	input  wire logic                  res_take,
	output logic [2:0]                 res_status,
	output logic [31:0]                res_match,
	output mem_ctl_t                   ctl,
	output logic [NW-1:0]              rd_addr,
	output logic [NW-1:0]              link_waddr,
	output logic [NW-1:0]              link_wdata,
	output logic [NW-1:0]              cnt_waddr,
	output logic [COUNT_BITS-1:0]      cnt_wdata,
	output logic [NW-1:0]              stk_raddr,
	output logic [NW-1:0]              stk_waddr,
	output logic [NW-1:0]              stk_wdata,
	output logic [NW-1:0]              low_mark,
	input  wire logic [NW-1:0]         link0_rd,
	input  wire logic [NW-1:0]         link1_rd,
	input  wire logic [COUNT_BITS-1:0] cnt_rd,
	input  wire logic [NW-1:0]         stk_rd
);

	state_t state_q, state_d;

	logic [1:0]            func_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [KEY_BITS-1:0]   sh_q;
	logic [KEY_BITS-1:0]   mask_q;
	logic [KEY_BITS-1:0]   acc_q;
	logic [LW-1:0]         lvl_q;
	logic [NW-1:0]         cur_q;
	logic [NW-1:0]         root0_q;
	logic [NW-1:0]         root1_q;
	logic [COUNT_BITS-1:0] root_cnt_q;
	logic [NW-1:0]         free_top_q;
	logic [NW-1:0]         low_q;
	logic [2:0]            status_q;
	logic [NW-1:0]         path_mem [2**LW];
	logic [NW-1:0]         path_rd_q;

	logic [KEY_BITS+31:0] key_ext;
	logic [KEY_BITS+31:0] acc_ext;
	logic                 b_fwd;
	logic                 b_back;
	logic [NW-1:0]        lnk_b;
	logic [NW-1:0]        lnk_o;
	logic                 at_root;
	logic                 last;
	logic                 alloc;
	logic [NW-1:0]        nx;
	logic [COUNT_BITS-1:0] dec_cnt;
	logic [NW-1:0]        parent;
	logic [NW-1:0]        top_dec;

	assign key_ext = {KEY_BITS'(0), req_key};
	assign acc_ext = {32'd0, acc_q};
	assign b_fwd   = sh_q[KEY_BITS-1];
	assign b_back  = sh_q[0];
	assign at_root = lvl_q == LW'(0);
	assign last    = lvl_q == LW'(KEY_BITS - 1);
	assign lnk_b   = at_root ? (b_fwd ? root1_q : root0_q) : (b_fwd ? link1_rd : link0_rd);
	assign lnk_o   = at_root ? (b_fwd ? root0_q : root1_q) : (b_fwd ? link0_rd : link1_rd);
	assign alloc   = lnk_b == NW'(0);
	assign nx      = alloc ? stk_rd : lnk_b;
	assign dec_cnt = (cnt_rd == COUNT_BITS'(0)) ? cnt_rd : cnt_rd - COUNT_BITS'(1);
	assign parent  = (lvl_q == LW'(1)) ? NW'(0) : path_rd_q;
	assign top_dec = free_top_q - NW'(1);

	assign req_ready  = state_q == S_IDLE;
	assign res_done   = state_q == S_DONE;
	assign res_status = status_q;
	assign res_match  = acc_ext[31:0];
	assign rd_addr    = cur_q;
	assign stk_raddr  = top_dec;
	assign stk_waddr  = free_top_q;
	assign stk_wdata  = cur_q;
	assign low_mark   = low_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_DISP;
			end
			S_DISP: begin
				case (func_q)
					FUNC_INSERT: begin
						if (free_top_q < NW'(KEY_BITS) || root_cnt_q == '1) state_d = S_DONE;
						else if (!allow_dup) state_d = S_WRD;
						else state_d = S_IRD;
					end
					FUNC_QUERY: state_d = (root_cnt_q == COUNT_BITS'(0)) ? S_DONE : S_QRD;
					default: state_d = S_WRD;
				endcase
			end
			S_WRD: state_d = S_WCHK;
			S_WCHK: begin
				if (alloc) begin
					state_d = (func_q == FUNC_INSERT) ? S_IRD : S_DONE;
				end else if (last) begin
					state_d = (func_q == FUNC_ERASE) ? S_ERD : S_DONE;
				end else begin
					state_d = S_WRD;
				end
			end
			S_IRD: state_d = S_ICHK;
			S_ICHK: begin
				if (alloc) state_d = S_ICLR;
				else state_d = last ? S_LRD : S_IRD;
			end
			S_ICLR: state_d = (lvl_q == LW'(KEY_BITS)) ? S_LRD : S_IRD;
			S_LRD:  state_d = S_LINC;
			S_LINC: state_d = S_DONE;
			S_ERD:  state_d = S_EUPD;
			S_EUPD: state_d = (lvl_q == LW'(1)) ? S_DONE : S_ERD;
			S_QRD:  state_d = S_QCHK;
			S_QCHK: begin
				if ((alloc && lnk_o == NW'(0)) || last) state_d = S_DONE;
				else state_d = S_QRD;
			end
			S_DONE: begin
				if (res_take) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl        = '0;
		link_waddr = cur_q;
		link_wdata = NW'(0);
		cnt_waddr  = cur_q;
		cnt_wdata  = cnt_rd + COUNT_BITS'(1);
		case (state_q)
			S_ICHK: begin
				if (alloc && !at_root) begin
					ctl.link_we0 = !b_fwd;
					ctl.link_we1 = b_fwd;
				end
				link_wdata = stk_rd;
				ctl.cnt_we = !at_root;
			end
			S_ICLR: begin
				ctl.link_we0 = 1'b1;
				ctl.link_we1 = 1'b1;
				ctl.cnt_we   = 1'b1;
				cnt_wdata    = COUNT_BITS'(0);
			end
			S_LINC: ctl.cnt_we = 1'b1;
			S_EUPD: begin
				ctl.cnt_we = 1'b1;
				cnt_wdata  = dec_cnt;
				link_waddr = parent;
				if (dec_cnt == COUNT_BITS'(0)) begin
					ctl.stk_we = 1'b1;
					if (lvl_q != LW'(1)) begin
						ctl.link_we0 = !b_back;
						ctl.link_we1 = b_back;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		path_rd_q <= path_mem[lvl_q - LW'(1)];
		if (state_q == S_WCHK && !alloc) begin
			path_mem[lvl_q + LW'(1)] <= lnk_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			root0_q    <= '0;
			root1_q    <= '0;
			root_cnt_q <= '0;
			free_top_q <= NW'(NODE_POOL - 1);
			low_q      <= NW'(NODE_POOL - 1);
		end else begin
			state_q <= state_d;
			case (state_q)
				S_ICHK: begin
					if (alloc) begin
						free_top_q <= top_dec;
						if (top_dec < low_q) low_q <= top_dec;
						if (at_root) begin
							if (b_fwd) root1_q <= stk_rd;
							else root0_q <= stk_rd;
						end
					end
					if (at_root) root_cnt_q <= root_cnt_q + COUNT_BITS'(1);
				end
				S_EUPD: begin
					if (dec_cnt == COUNT_BITS'(0)) begin
						free_top_q <= free_top_q + NW'(1);
						if (lvl_q == LW'(1)) begin
							if (b_back) root1_q <= '0;
							else root0_q <= '0;
						end
					end
					if (lvl_q == LW'(1) && root_cnt_q != COUNT_BITS'(0)) begin
						root_cnt_q <= root_cnt_q - COUNT_BITS'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q <= req_func;
				key_q  <= key_ext[KEY_BITS-1:0];
				sh_q   <= key_ext[KEY_BITS-1:0];
				mask_q <= KEY_BITS'(1) << (KEY_BITS - 1);
				acc_q  <= '0;
				lvl_q  <= '0;
				cur_q  <= '0;
			end
			S_DISP: begin
				if (func_q == FUNC_INSERT &&
				    (free_top_q < NW'(KEY_BITS) || root_cnt_q == '1)) begin
					status_q <= ST_FULL;
				end else if (func_q == FUNC_QUERY && root_cnt_q == COUNT_BITS'(0)) begin
					status_q <= ST_EMPTY;
				end else begin
					status_q <= ST_OK;
				end
			end
			S_WCHK: begin
				if (alloc) begin
					status_q <= (func_q == FUNC_INSERT) ? ST_OK : ST_NOTFOUND;
					sh_q     <= key_q;
					lvl_q    <= '0;
					cur_q    <= '0;
				end else begin
					cur_q <= lnk_b;
					lvl_q <= lvl_q + LW'(1);
					if (last) begin
						status_q <= (func_q == FUNC_INSERT) ? ST_DUP : ST_OK;
						sh_q     <= key_q;
					end else begin
						sh_q <= sh_q << 1;
					end
				end
			end
			S_ICHK: begin
				cur_q <= nx;
				lvl_q <= lvl_q + LW'(1);
				sh_q  <= sh_q << 1;
			end
			S_EUPD: begin
				cur_q <= parent;
				lvl_q <= lvl_q - LW'(1);
				sh_q  <= sh_q >> 1;
			end
			S_QCHK: begin
				if (!alloc) begin
					cur_q <= lnk_b;
					if (b_fwd) acc_q <= acc_q | mask_q;
				end else if (lnk_o != NW'(0)) begin
					cur_q <= lnk_o;
					if (!b_fwd) acc_q <= acc_q | mask_q;
				end
				lvl_q  <= lvl_q + LW'(1);
				sh_q   <= sh_q << 1;
				mask_q <= mask_q >> 1;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

### verif/tb_binary_trie_xor_min_set.sv
`timescale 1ns / 1ps
module tb_binary_trie_xor_min_set;
	import bxm_pkg::*;

	localparam int KEY_W     = 32;
	localparam int POOL      = 4096;
	localparam int CNT_MAX   = 65535;
	localparam int CYCLE_CAP = 2000000;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] match_key;
	} trie_result_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [1:0]  func = FUNC_LOOKUP;
	logic [31:0] key = '0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [2:0]  status;
	logic [31:0] match_key;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	binary_trie_xor_min_set dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// shadow trie
	logic [11:0] link_tbl [POOL][2];
	int unsigned cnt_tbl  [POOL];
	logic [11:0] free_tbl [POOL];
	int unsigned free_cnt;
	bit          dup_mode;

	trie_result_t result_q[$];
	logic [31:0]  known_keys[$];
	bit           idle_en = 1;
	int           errors = 0;
	int           n_req = 0;
	int           n_resp = 0;
	int           n_full = 0;
	int           n_dup = 0;
	int           cycles = 0;

	function automatic bit trie_walk(logic [31:0] k, output logic [11:0] path [0:KEY_W]);
		logic [11:0] nd;
		nd = 0;
		path[0] = 0;
		for (int i = 0; i < KEY_W; i++) begin
			nd = link_tbl[nd][k[KEY_W-1-i]];
			if (nd == 0)
				return 0;
			path[i+1] = nd;
		end
		return 1;
	endfunction

	function automatic trie_result_t trie_apply(logic [1:0] f, logic [31:0] k);
		trie_result_t r;
		logic [11:0] path [0:KEY_W];
		logic [11:0] nd, nx;
		logic b;
		r = '{status: ST_OK, match_key: '0};
		case (f)
			FUNC_INSERT: begin
				if (free_cnt < KEY_W || cnt_tbl[0] >= CNT_MAX)
					r.status = ST_FULL;
				else if (!dup_mode && trie_walk(k, path))
					r.status = ST_DUP;
				else begin
					nd = 0;
					for (int i = 0; i < KEY_W; i++) begin
						b = k[KEY_W-1-i];
						nx = link_tbl[nd][b];
						if (nx == 0) begin
							free_cnt--;
							nx = free_tbl[free_cnt];
							link_tbl[nx][0] = 0;
							link_tbl[nx][1] = 0;
							cnt_tbl[nx] = 0;
							link_tbl[nd][b] = nx;
						end
						cnt_tbl[nd]++;
						nd = nx;
					end
					cnt_tbl[nd]++;
				end
			end
			FUNC_LOOKUP:
				if (!trie_walk(k, path))
					r.status = ST_NOTFOUND;
			FUNC_ERASE: begin
				if (!trie_walk(k, path))
					r.status = ST_NOTFOUND;
				else begin
					for (int l = KEY_W; l > 0; l--) begin
						nd = path[l];
						if (cnt_tbl[nd] > 0)
							cnt_tbl[nd]--;
						if (cnt_tbl[nd] == 0) begin
							link_tbl[path[l-1]][k[KEY_W-l]] = 0;
							if (free_cnt < POOL) begin
								free_tbl[free_cnt] = nd;
								free_cnt++;
							end
						end
					end
					if (cnt_tbl[0] > 0)
						cnt_tbl[0]--;
				end
			end
			default: begin
				if (cnt_tbl[0] == 0)
					r.status = ST_EMPTY;
				else begin
					nd = 0;
					for (int i = 0; i < KEY_W; i++) begin
						b = k[KEY_W-1-i];
						nx = link_tbl[nd][b];
						if (nx == 0) begin
							b = ~b;
							nx = link_tbl[nd][b];
							if (nx == 0)
								break;
						end
						r.match_key[KEY_W-1-i] = b;
						nd = nx;
					end
				end
			end
		endcase
		return r;
	endfunction

	task automatic send_req(logic [1:0] f, logic [31:0] k);
		trie_result_t r;
		int gap;
		gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		func <= f;
		key <= k;
		do @(posedge clk); while (!in_ready);
		r = trie_apply(f, k);
		if (f == FUNC_INSERT && r.status == ST_OK)
			known_keys.push_back(k);
		if (r.status == ST_FULL)
			n_full++;
		if (r.status == ST_DUP)
			n_dup++;
		result_q.push_back(r);
		n_req++;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_dup_mode(bit v);
		drain();
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {REG_ALLOW_DUP, 2'b00};
		pwdata <= {31'd0, v};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		dup_mode = v;
	endtask

	// result checker
	always @(posedge clk) begin
		trie_result_t e;
		if (arst_n && out_valid && out_ready) begin
			n_resp++;
			if (result_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result status=%0d match_key=%h",
					$time, status, match_key);
			end else begin
				e = result_q.pop_front();
				if (status !== e.status) begin
					errors++;
					$display("%0t: status exp %0d got %0d", $time, e.status, status);
				end
				if (match_key !== e.match_key) begin
					errors++;
					$display("%0t: match_key exp %h got %h", $time, e.match_key, match_key);
				end
			end
		end
	end

	// result-side backpressure
	int stall_left = 0;
	always @(posedge clk) begin
		bit rdy;
		rdy = 1;
		if (stall_left > 0) begin
			stall_left--;
			rdy = 0;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 8);
			rdy = 0;
		end
		out_ready <= rdy;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("tb_binary_trie_xor_min_set: FAIL");
			$finish;
		end
	end

	task automatic test_basic_ops();
		send_req(FUNC_QUERY, 32'h1234_5678);
		send_req(FUNC_LOOKUP, 32'h0);
		send_req(FUNC_ERASE, 32'hFFFF_FFFF);
		send_req(FUNC_INSERT, 32'h0);
		send_req(FUNC_INSERT, 32'hFFFF_FFFF);
		send_req(FUNC_INSERT, 32'h0);
		send_req(FUNC_LOOKUP, 32'hFFFF_FFFF);
		send_req(FUNC_LOOKUP, 32'h8000_0000);
		send_req(FUNC_QUERY, 32'h0000_FFFF);
		send_req(FUNC_QUERY, 32'hFFFF_0000);
		send_req(FUNC_INSERT, 32'hA5A5_5A5A);
		send_req(FUNC_QUERY, 32'hA5A5_5A5B);
		send_req(FUNC_ERASE, 32'h0);
		send_req(FUNC_ERASE, 32'h0);
		send_req(FUNC_ERASE, 32'hFFFF_FFFF);
		send_req(FUNC_ERASE, 32'hA5A5_5A5A);
		send_req(FUNC_QUERY, 32'h0);
	endtask

	task automatic test_multiset();
		write_dup_mode(1);
		repeat (3) send_req(FUNC_INSERT, 32'h5555_AAAA);
		write_dup_mode(0);
		send_req(FUNC_INSERT, 32'h5555_AAAA);
		repeat (4) send_req(FUNC_ERASE, 32'h5555_AAAA);
		send_req(FUNC_LOOKUP, 32'h5555_AAAA);
	endtask

	task automatic test_pool_full();
		int n;
		n = 0;
		while (free_cnt >= KEY_W && n < 400) begin
			send_req(FUNC_INSERT, $urandom());
			n++;
		end
		send_req(FUNC_INSERT, $urandom());
		send_req(FUNC_INSERT, known_keys[0]);
		send_req(FUNC_QUERY, $urandom());
		while (known_keys.size() != 0)
			send_req(FUNC_ERASE, known_keys.pop_front());
		send_req(FUNC_QUERY, $urandom());
	endtask

	task automatic test_random(int n_items);
		logic [31:0] k;
		for (int i = 0; i < n_items; i++) begin
			if (i % 300 == 150)
				write_dup_mode(~dup_mode);
			if (i == n_items - 200)
				idle_en = 0;
			case ($urandom_range(0, 3))
				0: k = $urandom();
				1: k = $urandom() & 32'h0000_000F;
				default: begin
					k = known_keys.size() ? known_keys[$urandom_range(0, known_keys.size()-1)]
						: $urandom();
					if ($urandom_range(0, 2) == 0)
						k ^= 32'h1 << $urandom_range(0, 31);
				end
			endcase
			send_req(2'($urandom_range(0, 3)), k);
		end
	endtask

	initial begin
		for (int i = 0; i < POOL; i++) begin
			link_tbl[i][0] = 0;
			link_tbl[i][1] = 0;
			cnt_tbl[i] = 0;
			free_tbl[i] = 12'(i + 1);
		end
		free_cnt = POOL - 1;
		dup_mode = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_basic_ops();
		test_multiset();
		test_pool_full();
		test_random(850);
		drain();
		$display("Ran %0d requests, checked %0d results (%0d pool-full, %0d duplicate).",
			n_req, n_resp, n_full, n_dup);
		$display("Covered all four operations in set and multiset modes with random stalls.");
		if (errors == 0)
			$display("tb_binary_trie_xor_min_set: PASS");
		else
			$display("tb_binary_trie_xor_min_set: FAIL");
		$finish;
	end
endmodule

### filelist.f
sv/bxm_pkg.sv
sv/bxm_store.sv
sv/bxm_ctrl.sv
sv/binary_trie_xor_min_set.sv
verif/tb_binary_trie_xor_min_set.sv
